FILE: src/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

   localparam int MAX_STAGES  = 4;
   localparam int NUM_SEL     = 4;
   localparam int NUM_TABLES  = 9;
   localparam int ALPHA       = 26;
   localparam int SYM_W       = 8;
   localparam int LETTER_W    = 5;
   localparam int SEL_W       = 4;
   localparam int NUM_ACT_W   = 3;
   localparam int ROT_W       = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 5;
   localparam int TABLE_IDX_W = $clog2(NUM_TABLES);
   localparam int STAGE_CNT_W = $clog2(MAX_STAGES + 1);

   localparam logic [SYM_W-1:0] CHAR_A     = 8'h41;
   localparam logic [SYM_W-1:0] CHAR_Z     = 8'h5a;
   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEL_0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEL_3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ACTIVE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION   = 3'd5;

   localparam logic [8*ALPHA-1:0] WIRING [NUM_TABLES] = '{
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
      "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
      "AJDKSIRUXBLHWTMCQGZNPYFVOE",
      "BDFHJLCPRTXVZNYEIWGAKMUSQO",
      "ESOVPZJAYQUIRHXLNFTGKDCMWB",
      "VZBRGITYUPSDNHLXAWMJQOFECK",
      "JPGVOUMFYQBENHZRDKASXLICTW",
      "NZJHGRCXMYSWBOUFAIVLPEKQDT",
      "FKQHTLXOCBJSPDZRAMEWNIUYGV"
   };

   typedef logic [NUM_TABLES-1:0][ALPHA-1:0][LETTER_W-1:0] table_set_type;

   function automatic table_set_type build_fwd();
      table_set_type r;
      logic [SYM_W-1:0] ch;
      r = '0;
      for (int t = 0; t < NUM_TABLES; t++) begin
         for (int i = 0; i < ALPHA; i++) begin
            ch = WIRING[t][8*(ALPHA-1-i) +: 8];
            r[t][i] = LETTER_W'(ch - CHAR_A);
         end
      end
      return r;
   endfunction

   function automatic table_set_type build_inv();
      table_set_type r;
      logic [SYM_W-1:0] ch;
      logic [SYM_W-1:0] c;
      r = '0;
      for (int t = 0; t < NUM_TABLES; t++) begin
         for (int i = 0; i < ALPHA; i++) begin
            ch = WIRING[t][8*(ALPHA-1-i) +: 8];
            c = ch - CHAR_A;
            r[t][c[LETTER_W-1:0]] = LETTER_W'(i);
         end
      end
      return r;
   endfunction

   localparam table_set_type FWD_TABLE = build_fwd();
   localparam table_set_type INV_TABLE = build_inv();

   typedef struct packed {
      logic             command;
      logic [SYM_W-1:0] symbol_in;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol_out;
      logic             bad_char;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_SEL-1:0][SEL_W-1:0] sel;
      logic [STAGE_CNT_W-1:0]        num_active;
      logic [ROT_W-1:0]              rotation;
   } cfg_type;

   typedef struct packed {
      logic                command;
      logic                is_letter;
      logic                bad_char;
      logic [SYM_W-1:0]    symbol;
      logic [LETTER_W-1:0] letter;
   } cell_data_type;

endpackage

FILE: src/rsc_cell.sv
`timescale 1ns / 1ps

module rsc_cell
   import rsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [STAGE_CNT_W-1:0] cell_idx,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cell_data_type          in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cell_data_type          out_data
);

   logic                   valid_ff;
   logic                   valid_in;
   cell_data_type          data_ff;
   cell_data_type          data_in;
   logic                   active;
   logic                   decrypt;
   logic [STAGE_CNT_W-1:0] stage;
   logic [SEL_W-1:0]       tsel;
   logic [TABLE_IDX_W-1:0] tab;
   logic [LETTER_W:0]      fwd_idx;
   logic [LETTER_W:0]      inv_sum;
   logic [LETTER_W-1:0]    fwd_val;
   logic [LETTER_W-1:0]    inv_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      active  = cell_idx < cfg.num_active;
      decrypt = (in_data.command == CMD_DECRYPT);
      stage   = decrypt ? (cfg.num_active - cell_idx - STAGE_CNT_W'(1)) : cell_idx;
      tsel    = '0;
      for (int j = 0; j < NUM_SEL; j++) begin
         if (int'(stage) == j) begin
            tsel = cfg.sel[j];
         end
      end
      tab = (int'(tsel) < NUM_TABLES) ? TABLE_IDX_W'(tsel) : '0;

      // forward: table[(k - rot) mod 26]
      if (in_data.letter >= cfg.rotation) begin
         fwd_idx = {1'b0, in_data.letter} - {1'b0, cfg.rotation};
      end else begin
         fwd_idx = {1'b0, in_data.letter} + (LETTER_W+1)'(ALPHA) - {1'b0, cfg.rotation};
      end
      fwd_val = FWD_TABLE[tab][fwd_idx[LETTER_W-1:0]];

      // inverse: (position of k + rot) mod 26
      inv_sum = {1'b0, INV_TABLE[tab][in_data.letter]} + {1'b0, cfg.rotation};
      if (inv_sum >= (LETTER_W+1)'(ALPHA)) begin
         inv_sum = inv_sum - (LETTER_W+1)'(ALPHA);
      end
      inv_val = inv_sum[LETTER_W-1:0];

      data_in = in_data;
      if (active && in_data.is_letter) begin
         data_in.letter = decrypt ? inv_val : fwd_val;
      end

      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: src/rotor_substitution_cipher.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    req_payload (command, symbol_in)
// rsp_      out        rsp_valid/rsp_ready    rsp_payload (symbol_out, bad_char)
// csr_      in         csr_wr_en              csr_index, csr_wdata
//
// one beat per cycle sustained while rsp_ready is high; each beat is registered once in every cell of the chain
// each cell registers its beat and holds it while the next cell is stalled
// rsp_ready low stalls the chain from the end back; req_ready falls only when all cells are full
// synchronous reset empties the chain and loads the register defaults

module rotor_substitution_cipher
   import rsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [NUM_SEL-1:0][SEL_W-1:0] sel_ff;
   logic [NUM_ACT_W-1:0]          num_active_ff;
   logic [ROT_W-1:0]              rotation_ff;
   cfg_type                       cfg;

   logic          valid_chain [MAX_STAGES+1];
   logic          ready_chain [MAX_STAGES+1];
   cell_data_type data_chain  [MAX_STAGES+1];
   cell_data_type head_data;
   cell_data_type last_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= '0;
         num_active_ff <= NUM_ACT_W'(1);
         rotation_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEL_0:      sel_ff[0]     <= csr_wdata[SEL_W-1:0];
            CSR_SEL_1:      sel_ff[1]     <= csr_wdata[SEL_W-1:0];
            CSR_SEL_2:      sel_ff[2]     <= csr_wdata[SEL_W-1:0];
            CSR_SEL_3:      sel_ff[3]     <= csr_wdata[SEL_W-1:0];
            CSR_NUM_ACTIVE: num_active_ff <= csr_wdata[NUM_ACT_W-1:0];
            CSR_ROTATION:   rotation_ff   <= csr_wdata[ROT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.sel = sel_ff;
      if (int'(num_active_ff) > MAX_STAGES) begin
         cfg.num_active = STAGE_CNT_W'(MAX_STAGES);
      end else begin
         cfg.num_active = STAGE_CNT_W'(num_active_ff);
      end
      if (rotation_ff >= ROT_W'(ALPHA)) begin
         cfg.rotation = rotation_ff - ROT_W'(ALPHA);
      end else begin
         cfg.rotation = rotation_ff;
      end
   end

   always_comb begin
      head_data.command   = req_payload.command;
      head_data.symbol    = req_payload.symbol_in;
      head_data.is_letter = (req_payload.symbol_in >= CHAR_A) &&
                            (req_payload.symbol_in <= CHAR_Z);
      head_data.bad_char  = !head_data.is_letter &&
                            (req_payload.symbol_in != CHAR_SPACE);
      head_data.letter    = LETTER_W'(req_payload.symbol_in - CHAR_A);
   end

   assign data_chain[0]  = head_data;
   assign valid_chain[0] = req_valid;
   assign req_ready      = ready_chain[0];

   for (genvar g = 0; g < MAX_STAGES; g++) begin : g_cell
      rsc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (STAGE_CNT_W'(g)),
         .cfg       (cfg),
         .in_valid  (valid_chain[g]),
         .in_ready  (ready_chain[g]),
         .in_data   (data_chain[g]),
         .out_valid (valid_chain[g+1]),
         .out_ready (ready_chain[g+1]),
         .out_data  (data_chain[g+1])
      );
   end

   assign ready_chain[MAX_STAGES] = rsp_ready;
   assign rsp_valid               = valid_chain[MAX_STAGES];
   assign last_data               = data_chain[MAX_STAGES];

   always_comb begin
      if (last_data.is_letter) begin
         rsp_payload.symbol_out = {{(SYM_W-LETTER_W){1'b0}}, last_data.letter} + CHAR_A;
      end else begin
         rsp_payload.symbol_out = last_data.symbol;
      end
      rsp_payload.bad_char = last_data.bad_char;
   end

endmodule
